FILE: rtl/bca_pkg.sv
// Shared constants and types for the bitmap contiguous unit allocator.
package bca_pkg;

   localparam int ADDR_W   = 64;
   localparam int CNT_W    = 11;
   localparam int SHIFT_W  = 5;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 2;

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_NOFIT = 2'd1;
   localparam status_type ST_RANGE = 2'd2;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT_SHIFT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNITS_IN_USE = 2'd2;

   localparam logic [ADDR_W-1:0]  POOL_BASE_RST    = 64'd0;
   localparam logic [SHIFT_W-1:0] UNIT_SHIFT_RST   = 5'd12;
   localparam logic [CNT_W-1:0]   UNITS_IN_USE_RST = 11'd1024;

endpackage

FILE: rtl/bca_bitmap.sv
// Occupancy bitmap memory: one port, registered read, clearing sweep after reset.
module bca_bitmap import bca_pkg::*; #(
   parameter int WORD_BITS = 64,
   parameter int NWORDS    = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic                 wr_en,
   input  logic [((NWORDS > 1) ? $clog2(NWORDS) : 1)-1:0] addr,
   input  logic [WORD_BITS-1:0] wdata,
   output logic [WORD_BITS-1:0] rdata,
   output logic                 clr_busy
);

   localparam int WA_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam logic [WA_W-1:0] LAST_WORD = WA_W'(NWORDS - 1);

   logic [WORD_BITS-1:0] occ_ff [NWORDS];
   logic [WORD_BITS-1:0] rdata_ff;
   logic [WA_W-1:0]      clr_addr_ff, clr_addr_in;
   logic                 clr_busy_ff, clr_busy_in;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_WORD) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         occ_ff[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         occ_ff[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= occ_ff[addr];
      end
   end

   assign rdata    = rdata_ff;
   assign clr_busy = clr_busy_ff;

endmodule

FILE: rtl/bca_seg.sv
// Word search unit: finds the end of a free or used stretch and builds bit-range masks.
module bca_seg import bca_pkg::*; #(
   parameter int WORD_BITS = 64
) (
   input  logic [WORD_BITS-1:0]              word,
   input  logic [$clog2(WORD_BITS)-1:0]      bit_off,
   input  logic [$clog2(WORD_BITS+1)-1:0]    lim,
   input  logic [$clog2(WORD_BITS+1)-1:0]    end_pos,
   output logic                              bit_free,
   output logic [$clog2(WORD_BITS+1)-1:0]    stretch_end,
   output logic [WORD_BITS-1:0]              mask
);

   localparam int LW = $clog2(WORD_BITS + 1);

   logic [WORD_BITS-1:0] taken;
   logic [WORD_BITS-1:0] tgt;

   always_comb begin
      // bits past the pool end count as taken, so no run crosses it
      for (int j = 0; j < WORD_BITS; j++) begin
         taken[j] = word[j] | (LW'(j) >= lim);
      end
      bit_free = ~taken[bit_off];
      for (int j = 0; j < WORD_BITS; j++) begin
         tgt[j]  = (bit_free ? taken[j] : ~taken[j]) & (LW'(j) >= LW'(bit_off));
         mask[j] = (LW'(j) >= LW'(bit_off)) && (LW'(j) < end_pos);
      end
      stretch_end = LW'(WORD_BITS);
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (tgt[j]) begin
            stretch_end = LW'(j);
         end
      end
   end

endmodule

FILE: rtl/bitmap_contiguous_unit_allocator.sv
// Top level: first-fit contiguous unit allocator over an occupancy bitmap.
//
//  channel | direction | handshake            | beat contents
//  --------+-----------+----------------------+-----------------------------------------
//  req     | in        | req_valid/req_ready  | req_type, req_unit_count, req_free_address
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_status, rsp_alloc_address,
//          |           |                      | rsp_units_allocated
//  csr     | in        | csr_wr_en only       | csr_index, csr_wdata
//
//  One request is worked on at a time; all bitmap traffic goes through one memory port
//  and one word search unit (bca_seg).
//  Allocate: after the accept, each bitmap word scanned is fetched, then walked one
//  free/used stretch at a time; each word of the run is fetched and marked; then a last
//  check, the address (index shifted, plus base) and the hand-off follow.
//  Free: address minus base, shift, range check, then whole words peeled off the index;
//  each word of the run is fetched, cleared and counted; then a last check and hand-off.
//  Reset starts a sweep that zeroes the bitmap, one word per cycle;
//  req_ready stays low until it ends, csr writes are taken throughout.
//  A finished result sits in the output register; the next request is accepted while it
//  waits, and only that request's completion stalls on rsp_ready.
module bitmap_contiguous_unit_allocator import bca_pkg::*; #(
   parameter int UNITS     = 1024,
   parameter int WORD_BITS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_type,
   input  logic [CNT_W-1:0]     req_unit_count,
   input  logic [ADDR_W-1:0]    req_free_address,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [ADDR_W-1:0]    rsp_alloc_address,
   output logic [CNT_W-1:0]     rsp_units_allocated,
   // configuration writes
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_wdata
);

   localparam int NWORDS = (UNITS + WORD_BITS - 1) / WORD_BITS;
   localparam int WA_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int BW     = $clog2(WORD_BITS);
   localparam int LW     = $clog2(WORD_BITS + 1);
   localparam int UW_RAW = $clog2(NWORDS * WORD_BITS + 1);
   localparam int UW     = (UW_RAW > CNT_W + 1) ? UW_RAW : CNT_W + 1;

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_ARD   = 4'd1;   // alloc: fetch next word
   localparam logic [3:0] S_ASCAN = 4'd2;   // alloc: walk stretches of the word
   localparam logic [3:0] S_WRD   = 4'd3;   // mark/clear: fetch word
   localparam logic [3:0] S_WMOD  = 4'd4;   // mark/clear: write word back
   localparam logic [3:0] S_FCNT  = 4'd5;   // free: count cleared bits
   localparam logic [3:0] S_FSUB  = 4'd6;   // free: address minus base
   localparam logic [3:0] S_FSH   = 4'd7;   // free: shift down to unit index
   localparam logic [3:0] S_FCMP  = 4'd8;   // free: range check
   localparam logic [3:0] S_FDIV  = 4'd9;   // free: index to word and bit
   localparam logic [3:0] S_ADDR1 = 4'd10;  // alloc: index shifted by unit size
   localparam logic [3:0] S_ADDR2 = 4'd11;  // alloc: plus base
   localparam logic [3:0] S_DONE  = 4'd12;  // hand result to output register

   function automatic logic [LW-1:0] pop_count(input logic [WORD_BITS-1:0] v);
      logic [LW-1:0] acc;
      acc = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         acc = acc + LW'(v[j]);
      end
      return acc;
   endfunction

   // configuration
   logic [ADDR_W-1:0]  pool_base_ff;
   logic [SHIFT_W-1:0] unit_shift_ff;
   logic [CNT_W-1:0]   units_in_use_ff;

   // sequencer and work registers
   logic [3:0]           state_ff, state_in;
   logic                 is_free_ff, is_free_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic [ADDR_W-1:0]    faddr_ff, faddr_in;
   logic [WA_W-1:0]      wa_ff, wa_in;
   logic [UW-1:0]        wb_ff, wb_in;
   logic [BW-1:0]        b_ff, b_in;
   logic [UW-1:0]        run_ff, run_in;
   logic [WA_W-1:0]      start_wa_ff, start_wa_in;
   logic [UW-1:0]        start_wb_ff, start_wb_in;
   logic [BW-1:0]        start_b_ff, start_b_in;
   logic [UW-1:0]        r_ff, r_in;
   logic [LW-1:0]        lim_ff, lim_in;
   logic [WORD_BITS-1:0] cleared_ff, cleared_in;
   logic [ADDR_W-1:0]    diff_ff, diff_in;
   logic [CNT_W-1:0]     used_ff, used_in;
   status_type           status_ff, status_in;
   logic [ADDR_W-1:0]    res_addr_ff, res_addr_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;
   logic [CNT_W-1:0]     rsp_used_ff, rsp_used_in;

   // memory and search unit
   logic                 mem_rd, mem_wr, clr_busy;
   logic [WORD_BITS-1:0] mem_wdata, mem_rdata;
   logic                 seg_free;
   logic [LW-1:0]        seg_end, end_pos;
   logic [WORD_BITS-1:0] seg_mask;

   // combinational helpers
   logic [UW-1:0]     units;
   logic [UW-1:0]     units_left;
   logic [LW-1:0]     word_lim;
   logic [LW-1:0]     len;
   logic [UW-1:0]     run_sum;
   logic [UW-1:0]     pos_sum;
   logic [LW-1:0]     take;
   logic [ADDR_W:0]   sub_full;
   logic              req_fire;

   assign req_fire = req_valid & req_ready;
   assign req_ready = (state_ff == S_IDLE) && !clr_busy;

   // effective pool size is min(units_in_use, UNITS)
   assign units = (UW'(units_in_use_ff) < UW'(UNITS)) ? UW'(units_in_use_ff) : UW'(UNITS);
   assign units_left = units - wb_ff;
   assign word_lim = (units_left >= UW'(WORD_BITS)) ? LW'(WORD_BITS) : units_left[LW-1:0];

   assign len     = seg_end - LW'(b_ff);
   assign run_sum = run_ff + UW'(len);
   assign pos_sum = UW'(b_ff) + r_ff;
   assign end_pos = (pos_sum >= UW'(lim_ff)) ? lim_ff : pos_sum[LW-1:0];
   assign take    = (end_pos > LW'(b_ff)) ? (end_pos - LW'(b_ff)) : '0;
   assign sub_full = {1'b0, faddr_ff} - {1'b0, pool_base_ff};

   assign mem_wdata = is_free_ff ? (mem_rdata & ~seg_mask) : (mem_rdata | seg_mask);

   bca_bitmap #(
      .WORD_BITS (WORD_BITS),
      .NWORDS    (NWORDS)
   ) u_bitmap (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (mem_rd),
      .wr_en    (mem_wr),
      .addr     (wa_ff),
      .wdata    (mem_wdata),
      .rdata    (mem_rdata),
      .clr_busy (clr_busy)
   );

   bca_seg #(
      .WORD_BITS (WORD_BITS)
   ) u_seg (
      .word        (mem_rdata),
      .bit_off     (b_ff),
      .lim         (lim_ff),
      .end_pos     (end_pos),
      .bit_free    (seg_free),
      .stretch_end (seg_end),
      .mask        (seg_mask)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff    <= POOL_BASE_RST;
         unit_shift_ff   <= UNIT_SHIFT_RST;
         units_in_use_ff <= UNITS_IN_USE_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_POOL_BASE:    pool_base_ff    <= csr_wdata;
            CSR_UNIT_SHIFT:   unit_shift_ff   <= csr_wdata[SHIFT_W-1:0];
            CSR_UNITS_IN_USE: units_in_use_ff <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      is_free_in  = is_free_ff;
      n_in        = n_ff;
      faddr_in    = faddr_ff;
      wa_in       = wa_ff;
      wb_in       = wb_ff;
      b_in        = b_ff;
      run_in      = run_ff;
      start_wa_in = start_wa_ff;
      start_wb_in = start_wb_ff;
      start_b_in  = start_b_ff;
      r_in        = r_ff;
      lim_in      = lim_ff;
      cleared_in  = cleared_ff;
      diff_in     = diff_ff;
      used_in     = used_ff;
      status_in   = status_ff;
      res_addr_in = res_addr_ff;
      mem_rd      = 1'b0;
      mem_wr      = 1'b0;

      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_used_in   = rsp_used_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               is_free_in  = req_type;
               n_in        = req_unit_count;
               faddr_in    = req_free_address;
               status_in   = ST_OK;
               res_addr_in = '0;
               wa_in       = '0;
               wb_in       = '0;
               b_in        = '0;
               run_in      = '0;
               if (req_type == REQ_FREE) begin
                  state_in = S_FSUB;
               end else if (req_unit_count == '0 || UW'(req_unit_count) > units) begin
                  status_in = ST_NOFIT;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_ARD;
               end
            end
         end
         S_ARD: begin
            if (wb_ff >= units) begin
               status_in = ST_NOFIT;
               state_in  = S_DONE;
            end else begin
               mem_rd   = 1'b1;
               lim_in   = word_lim;
               state_in = S_ASCAN;
            end
         end
         S_ASCAN: begin
            if (seg_free && run_sum >= UW'(n_ff)) begin
               // run found; a fresh run starts right here
               if (run_ff == '0) begin
                  start_wa_in = wa_ff;
                  start_wb_in = wb_ff;
                  start_b_in  = b_ff;
               end
               wa_in    = (run_ff == '0) ? wa_ff : start_wa_ff;
               wb_in    = (run_ff == '0) ? wb_ff : start_wb_ff;
               b_in     = (run_ff == '0) ? b_ff : start_b_ff;
               r_in     = UW'(n_ff);
               state_in = S_WRD;
            end else begin
               if (seg_free) begin
                  run_in = run_sum;
                  if (run_ff == '0) begin
                     start_wa_in = wa_ff;
                     start_wb_in = wb_ff;
                     start_b_in  = b_ff;
                  end
               end else begin
                  run_in = '0;
               end
               if (seg_end == LW'(WORD_BITS)) begin
                  wa_in    = wa_ff + 1'b1;
                  wb_in    = wb_ff + UW'(WORD_BITS);
                  b_in     = '0;
                  state_in = S_ARD;
               end else begin
                  b_in = seg_end[BW-1:0];
               end
            end
         end
         S_WRD: begin
            if (r_ff == '0 || wb_ff >= units) begin
               state_in = is_free_ff ? S_DONE : S_ADDR1;
            end else begin
               mem_rd   = 1'b1;
               lim_in   = word_lim;
               state_in = S_WMOD;
            end
         end
         S_WMOD: begin
            mem_wr     = 1'b1;
            cleared_in = mem_rdata & seg_mask;
            r_in       = r_ff - UW'(take);
            wa_in      = wa_ff + 1'b1;
            wb_in      = wb_ff + UW'(WORD_BITS);
            b_in       = '0;
            state_in   = is_free_ff ? S_FCNT : S_WRD;
         end
         S_FCNT: begin
            used_in  = used_ff - CNT_W'(pop_count(cleared_ff));
            state_in = S_WRD;
         end
         S_FSUB: begin
            if (sub_full[ADDR_W]) begin
               status_in = ST_RANGE;
               state_in  = S_DONE;
            end else begin
               diff_in  = sub_full[ADDR_W-1:0];
               state_in = S_FSH;
            end
         end
         S_FSH: begin
            diff_in  = diff_ff >> unit_shift_ff;
            state_in = S_FCMP;
         end
         S_FCMP: begin
            if (diff_ff >= ADDR_W'(units)) begin
               status_in = ST_RANGE;
               state_in  = S_DONE;
            end else begin
               run_in   = diff_ff[UW-1:0];
               r_in     = UW'(n_ff);
               state_in = S_FDIV;
            end
         end
         S_FDIV: begin
            // peel whole words off the unit index
            if (run_ff >= UW'(WORD_BITS)) begin
               run_in = run_ff - UW'(WORD_BITS);
               wa_in  = wa_ff + 1'b1;
               wb_in  = wb_ff + UW'(WORD_BITS);
            end else begin
               b_in     = run_ff[BW-1:0];
               state_in = S_WRD;
            end
         end
         S_ADDR1: begin
            diff_in  = ADDR_W'(start_wb_ff + UW'(start_b_ff)) << unit_shift_ff;
            used_in  = used_ff + n_ff;
            state_in = S_ADDR2;
         end
         S_ADDR2: begin
            res_addr_in = pool_base_ff + diff_ff;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_addr_in   = res_addr_ff;
               rsp_used_in   = used_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_free_ff    <= is_free_in;
      n_ff          <= n_in;
      faddr_ff      <= faddr_in;
      wa_ff         <= wa_in;
      wb_ff         <= wb_in;
      b_ff          <= b_in;
      run_ff        <= run_in;
      start_wa_ff   <= start_wa_in;
      start_wb_ff   <= start_wb_in;
      start_b_ff    <= start_b_in;
      r_ff          <= r_in;
      lim_ff        <= lim_in;
      cleared_ff    <= cleared_in;
      diff_ff       <= diff_in;
      status_ff     <= status_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_used_ff   <= rsp_used_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_alloc_address   = rsp_addr_ff;
   assign rsp_units_allocated = rsp_used_ff;

endmodule

FILE: rtl/bca_checker.sv
// Port-level checks for the allocator, bound to the top level.
module bca_checker import bca_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [ADDR_W-1:0]   rsp_alloc_address,
   input logic [CNT_W-1:0]    rsp_units_allocated
);

   // only three status codes exist
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_NOFIT ||
                     rsp_status == ST_RANGE))
      else $error("bca: undefined status code");

   // a failed request never reports an address
   a_err_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_alloc_address == '0))
      else $error("bca: error beat carries an address");

   // bitmap sweep holds off requests, and no result survives reset
   a_post_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (!req_ready && !rsp_valid))
      else $error("bca: busy or result right after reset");

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) &&
         $stable(rsp_alloc_address) && $stable(rsp_units_allocated)))
      else $error("bca: result beat changed while stalled");

endmodule

bind bitmap_contiguous_unit_allocator bca_checker u_bca_checker (.*);

FILE: verif/bitmap_contiguous_unit_allocator_tb.sv
// Self-checking testbench for the bitmap contiguous unit allocator.
module bitmap_contiguous_unit_allocator_tb;
   import bca_pkg::*;

   localparam int POOL_UNITS     = 1024;
   localparam int WATCHDOG_LIMIT = 20000;  // quiet cycles
   localparam int DRAIN_CYCLES   = 60;
   localparam int MAX_PRINTED    = 40;

   // One request beat as the driver presents it.
   typedef struct {
      logic              kind;
      logic [CNT_W-1:0]  count;
      logic [ADDR_W-1:0] addr;
   } unit_req_type;

   // One result beat, plus the request number it belongs to.
   typedef struct {
      status_type        status;
      logic [ADDR_W-1:0] addr;
      logic [CNT_W-1:0]  used;
      int                seq;
   } alloc_rsp_type;

   // A run handed out by the block; candidates for well-formed frees.
   typedef struct {
      logic [ADDR_W-1:0] addr;
      logic [CNT_W-1:0]  count;
   } held_run_type;

   logic                 clock;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_ready;
   logic                 req_type         = REQ_ALLOC;
   logic [CNT_W-1:0]     req_unit_count   = '0;
   logic [ADDR_W-1:0]    req_free_address = '0;
   logic                 rsp_valid;
   logic                 rsp_ready        = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [ADDR_W-1:0]    rsp_alloc_address;
   logic [CNT_W-1:0]     rsp_units_allocated;
   logic                 csr_wr_en        = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index        = '0;
   logic [ADDR_W-1:0]    csr_wdata        = '0;

   bitmap_contiguous_unit_allocator dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_unit_count      (req_unit_count),
      .req_free_address    (req_free_address),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_alloc_address   (rsp_alloc_address),
      .rsp_units_allocated (rsp_units_allocated),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Shadow of the block: occupancy bitmap, used count and register copies.
   logic [POOL_UNITS-1:0] occ_map    = '0;
   logic [CNT_W-1:0]      used_units = '0;
   logic [ADDR_W-1:0]     cfg_base   = POOL_BASE_RST;
   logic [SHIFT_W-1:0]    cfg_shift  = UNIT_SHIFT_RST;
   logic [CNT_W-1:0]      cfg_units  = UNITS_IN_USE_RST;

   unit_req_type  req_backlog[$];       // beats waiting for the driver
   alloc_rsp_type pending_outcomes[$];  // predicted results, oldest first
   held_run_type  held_runs[$];

   int send_idle_pct = 24;
   int recv_idle_pct = 60;
   int mismatches    = 0;
   int accepted_reqs = 0;
   int quiet_cycles  = 0;
   logic req_taken   = 1'b0;

   function automatic logic [ADDR_W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // Units actually managed: the register, clamped to the bitmap size.
   function automatic int live_units();
      return (int'(cfg_units) < POOL_UNITS) ? int'(cfg_units) : POOL_UNITS;
   endfunction

   // Some byte address inside unit idx (random offset within the unit).
   function automatic logic [ADDR_W-1:0] unit_address(int idx);
      return cfg_base + (64'(idx) << cfg_shift)
             + (rand_word() & ((64'd1 << cfg_shift) - 64'd1));
   endfunction

   // First-fit allocate or range-checked free against the shadow bitmap.
   // Updates the shadow and returns the result the block must give.
   function automatic alloc_rsp_type first_fit_outcome(unit_req_type r);
      alloc_rsp_type o;
      held_run_type  h;
      logic [ADDR_W-1:0] idx;
      int live, n, run, start, u;
      bit found;
      live     = live_units();
      n        = int'(r.count);
      o.status = ST_OK;
      o.addr   = '0;
      run      = 0;
      start    = 0;
      found    = 1'b0;
      if (r.kind == REQ_ALLOC) begin
         // zero-length and longer-than-pool requests never search
         if (n != 0 && n <= live) begin
            for (u = 0; u < live && !found; u++) begin
               if (occ_map[u]) begin
                  run = 0;
               end else begin
                  if (run == 0) start = u;
                  run++;
                  if (run >= n) found = 1'b1;
               end
            end
         end
         if (found) begin
            for (u = start; u < start + n; u++) begin
               if (!occ_map[u]) begin
                  occ_map[u] = 1'b1;
                  used_units++;
               end
            end
            o.addr  = cfg_base + (64'(start) << cfg_shift);
            h.addr  = o.addr;
            h.count = r.count;
            held_runs.push_back(h);
         end else begin
            o.status = ST_NOFIT;
         end
      end else if (r.addr < cfg_base) begin
         o.status = ST_RANGE;
      end else begin
         idx = (r.addr - cfg_base) >> cfg_shift;
         if (idx >= 64'(live)) begin
            o.status = ST_RANGE;
         end else begin
            // clear only set bits, and stop at the last managed unit
            for (u = 0; u < n && int'(idx) + u < live; u++) begin
               if (occ_map[int'(idx) + u]) begin
                  occ_map[int'(idx) + u] = 1'b0;
                  used_units--;
               end
            end
         end
      end
      o.used = used_units;
      o.seq  = accepted_reqs;
      return o;
   endfunction

   function automatic unit_req_type make_req(logic kind, int count, logic [ADDR_W-1:0] addr);
      unit_req_type r;
      r.kind  = kind;
      r.count = CNT_W'(count);
      r.addr  = addr;
      return r;
   endfunction

   // Mostly alloc/free of runs actually held, with some noise mixed in.
   function automatic unit_req_type random_request();
      unit_req_type r;
      held_run_type h;
      int live, roll, pick, free_pct;
      live     = live_units();
      r.kind   = REQ_ALLOC;
      r.addr   = rand_word();   // don't-care for allocates
      r.count  = CNT_W'(1);
      roll     = $urandom_range(99);
      free_pct = (4 * int'(used_units) > 3 * live) ? 70 : 45;
      if (roll < 10) begin
         // noise: any value of every field
         r.kind  = 1'($urandom);
         r.count = CNT_W'($urandom);
      end else if (roll < 16) begin
         // free somewhere inside or just past the pool
         r.kind  = REQ_FREE;
         r.count = CNT_W'($urandom_range(40, 0));
         r.addr  = unit_address($urandom_range(live + 2));
      end else if (held_runs.size() != 0 && roll < free_pct) begin
         pick = $urandom_range(held_runs.size() - 1);
         h    = held_runs[pick];
         held_runs.delete(pick);
         r.kind  = REQ_FREE;
         r.addr  = h.addr;
         r.count = h.count;
         case ($urandom_range(9))
            0: r.count = CNT_W'($urandom_range(int'(h.count), 1));
            1: r.count = h.count + CNT_W'($urandom_range(30));
            2: r.addr  = h.addr + (rand_word() & ((64'd1 << cfg_shift) - 64'd1));
            default: ;
         endcase
      end else begin
         roll = $urandom_range(99);
         if (roll < 70)      r.count = CNT_W'($urandom_range(8, 1));
         else if (roll < 88) r.count = CNT_W'($urandom_range(64, 9));
         else if (roll < 95) r.count = CNT_W'($urandom_range(POOL_UNITS, 65));
         else if (roll < 97) r.count = '0;
         else                r.count = CNT_W'($urandom);
      end
      return r;
   endfunction

   task automatic report_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("mismatch at %0t: %s", $time, what);
   endtask

   // Register write; only issued while the block is idle, so the shadow
   // copy can follow at once. Upper data bits beyond the register are junk.
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_POOL_BASE:    cfg_base  = data;
         CSR_UNIT_SHIFT:   cfg_shift = data[SHIFT_W-1:0];
         CSR_UNITS_IN_USE: cfg_units = data[CNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [ADDR_W-1:0] base, int shift, int units);
      write_csr(CSR_POOL_BASE, base);
      write_csr(CSR_UNIT_SHIFT, (rand_word() & ~64'h1F) | 64'(shift));
      write_csr(CSR_UNITS_IN_USE, (rand_word() & ~64'h7FF) | 64'(units));
   endtask

   task automatic wait_idle();
      while (req_backlog.size() != 0 || req_valid || pending_outcomes.size() != 0)
         @(posedge clock);
   endtask

   // Request driver: new beat at the falling edge once the last one was taken.
   always @(negedge clock) begin : req_driver
      unit_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = req_backlog.pop_front();
            req_valid        <= 1'b1;
            req_type         <= nxt.kind;
            req_unit_count   <= nxt.count;
            req_free_address <= nxt.addr;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Monitor: predict on request beats, check result beats, watch for hangs.
   always @(posedge clock) begin : beat_monitor
      alloc_rsp_type want;
      unit_req_type  seen;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         // results first: a result beat never belongs to a request taken this edge
         if (rsp_valid && rsp_ready) begin
            if (pending_outcomes.size() == 0) begin
               report_mismatch($sformatf("result beat with none outstanding, status %0d",
                                         rsp_status));
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("req %0d status %0d, want %0d",
                                            want.seq, rsp_status, want.status));
               if (rsp_alloc_address !== want.addr)
                  report_mismatch($sformatf("req %0d address %h, want %h",
                                            want.seq, rsp_alloc_address, want.addr));
               if (rsp_units_allocated !== want.used)
                  report_mismatch($sformatf("req %0d units_allocated %0d, want %0d",
                                            want.seq, rsp_units_allocated, want.used));
            end
         end
         if (req_valid && req_ready) begin
            seen.kind  = req_type;
            seen.count = req_unit_count;
            seen.addr  = req_free_address;
            pending_outcomes.push_back(first_fit_outcome(seen));
            accepted_reqs++;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [ADDR_W-1:0] base, pb;
      int p, i, shift, units, items;
      base = 64'h0000_0040_0000_0000;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: 4 KiB units, full 1024-unit pool
      configure(base, 12, 1024);
      req_backlog.push_back(make_req(REQ_ALLOC, 0, rand_word()));     // zero-length
      req_backlog.push_back(make_req(REQ_ALLOC, 2047, rand_word()));  // widest count
      req_backlog.push_back(make_req(REQ_ALLOC, 1025, rand_word()));  // one past the pool
      req_backlog.push_back(make_req(REQ_ALLOC, 1024, '0));           // whole pool
      req_backlog.push_back(make_req(REQ_ALLOC, 1, '1));              // pool full
      // free running past the last unit clears 1000..1023 only
      req_backlog.push_back(make_req(REQ_FREE, 2047, base + (64'd1000 << 12)));
      req_backlog.push_back(make_req(REQ_FREE, 1, base - 64'd1));     // just below
      req_backlog.push_back(make_req(REQ_FREE, 5, '0));
      req_backlog.push_back(make_req(REQ_FREE, 1, '1));
      req_backlog.push_back(make_req(REQ_FREE, 1, base + (64'd1024 << 12)));  // at the end
      // zero-length free on the last byte of the pool
      req_backlog.push_back(make_req(REQ_FREE, 0, base + (64'd1023 << 12) + 64'hFFF));
      req_backlog.push_back(make_req(REQ_ALLOC, 24, '0));             // tail hole
      req_backlog.push_back(make_req(REQ_FREE, 1024, base + 64'h123));  // mid-unit address
      req_backlog.push_back(make_req(REQ_ALLOC, 64, '0));             // fills word 0
      req_backlog.push_back(make_req(REQ_ALLOC, 64, '0));             // fills word 1
      req_backlog.push_back(make_req(REQ_FREE, 63, base));
      req_backlog.push_back(make_req(REQ_FREE, 1, base + (64'd63 << 12)));
      // word 0 free, word 1 full: the run must start after the full word
      req_backlog.push_back(make_req(REQ_ALLOC, 100, '0));
      req_backlog.push_back(make_req(REQ_ALLOC, 64, '0));             // exact fit, word 0
      req_backlog.push_back(make_req(REQ_FREE, 2047, base + (64'd64 << 12)));
      req_backlog.push_back(make_req(REQ_ALLOC, 1, '0));
      req_backlog.push_back(make_req(REQ_FREE, 1, base + (64'd64 << 12) + 64'hFFF));

      for (p = 0; p < 7; p++) begin
         wait_idle();
         case (p)
            0: begin pb = 64'h0000_0000_8000_0000; shift = 12; units = 1024; items = 150; end
            // pool runs past the top of the address space
            1: begin pb = 64'hFFFF_FFFF_FFFF_0000; shift = 8;  units = 1024; items = 150; end
            2: begin pb = '0;                      shift = 0;  units = 2;    items = 120; end
            // shrunk pool: bits above unit 100 stay set and keep counting
            3: begin pb = rand_word();             shift = 31; units = 100;  items = 150; end
            // empty pool: every allocate and free fails
            4: begin pb = 64'h1234_5678_9ABC_D000; shift = 6;  units = 0;    items = 30;  end
            // register above the bitmap size clamps to 1024 units
            5: begin pb = '1;                      shift = 30; units = 2047; items = 150; end
            default: begin pb = rand_word();       shift = 3;  units = 700;  items = 180; end
         endcase
         // sender slow / receiver slower, then swapped, then full rate
         if (p < 2) begin
            send_idle_pct = 24;
            recv_idle_pct = 60;
         end else if (p < 4) begin
            send_idle_pct = 60;
            recv_idle_pct = 24;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         configure(pb, shift, units);
         held_runs.delete();
         // start each phase from an empty managed range
         req_backlog.push_back(make_req(REQ_FREE, 2047, cfg_base));
         for (i = 0; i < items; i++) begin
            while (req_backlog.size() != 0) @(posedge clock);
            req_backlog.push_back(random_request());
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: bitmap_contiguous_unit_allocator.f
rtl/bca_pkg.sv
rtl/bca_bitmap.sv
rtl/bca_seg.sv
rtl/bitmap_contiguous_unit_allocator.sv
rtl/bca_checker.sv
verif/bitmap_contiguous_unit_allocator_tb.sv
